// ===== rtl/number_to_ascii_formatter_defines.svh =====
// -----------------------------------------------------------------------------
// Number to ASCII formatter assertion macros
// Shared property forms for the concurrent checks of the formatter.
// -----------------------------------------------------------------------------
`ifndef NUMBER_TO_ASCII_FORMATTER_DEFINES_SVH
`define NUMBER_TO_ASCII_FORMATTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define N2A_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define N2A_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/n2a_pkg.sv =====
// -----------------------------------------------------------------------------
// Number to ASCII formatter package
// Command codes, character constants and the pipeline payload type.
// -----------------------------------------------------------------------------
package n2a_pkg;

  localparam int unsigned CmdW     = 3;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned CharW    = 8;
  localparam int unsigned MaxChars = 8;
  localparam int unsigned BcdW     = 20;
  localparam int unsigned ShiftW   = BcdW + ValueW;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 8;

  localparam logic [CmdW-1:0] CMD_HEX_BYTE  = 3'd0;
  localparam logic [CmdW-1:0] CMD_HEX_WORD  = 3'd1;
  localparam logic [CmdW-1:0] CMD_BIN_BYTE  = 3'd2;
  localparam logic [CmdW-1:0] CMD_UDEC_BYTE = 3'd3;
  localparam logic [CmdW-1:0] CMD_SDEC_BYTE = 3'd4;
  localparam logic [CmdW-1:0] CMD_UDEC_WORD = 3'd5;
  localparam logic [CmdW-1:0] CMD_NEWLINE   = 3'd6;

  localparam logic [CharW-1:0] CHAR_ZERO   = 8'd48;
  localparam logic [CharW-1:0] CHAR_ONE    = 8'd49;
  localparam logic [CharW-1:0] CHAR_ALPHA  = 8'd55;
  localparam logic [CharW-1:0] CHAR_MINUS  = 8'd45;
  localparam logic [CharW-1:0] CHAR_CR     = 8'd13;
  localparam logic [CharW-1:0] CHAR_LF     = 8'd10;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [ValueW-1:0] value;
    logic              neg;
    logic [ShiftW-1:0] sr;
  } pipe_t;

endpackage

// ===== rtl/number_to_ascii_formatter.sv =====
// -----------------------------------------------------------------------------
// Number to ASCII formatter
// Turns a format command and a 16-bit value into a run of ASCII characters.
// -----------------------------------------------------------------------------
// Usage:
// An item enters on the s_axis channel: tdata carries the command in bits
// 2:0 and the value in bits 18:3. Each item gives one to eight characters on
// the m_axis channel, one character per item there, with tlast on the final
// character of the run. Command 7 gives no characters.
// The value passes a five-stage pipeline (sign handling, then four stages
// of four binary-to-BCD steps each) and then a character buffer that sends
// one character per cycle while the receiver is ready. The first character
// of an item shows on m_axis once the buffer has loaded it from the last stage.
// An item can be accepted in every cycle until the pipeline fills; in steady
// state the output rate of one character per cycle sets the pace, as an item
// leaves the pipeline only when the buffer is free for its characters.
// Reset clears all valid flags; no item is held afterwards. When the
// receiver stalls, the character buffer holds its item and the pipeline
// fills stage by stage before s_axis_tready drops; nothing is lost.
// -----------------------------------------------------------------------------
`include "number_to_ascii_formatter_defines.svh"

module number_to_ascii_formatter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // Fields from bit 0 up: cmd [2:0], value [18:3], zero fill [23:19].
  input  logic [n2a_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // Fields from bit 0 up: ascii_char [7:0].
  output logic [n2a_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                         m_axis_tlast_o
);

  import n2a_pkg::*;

  localparam int unsigned Stages = 5;

  function automatic logic [ShiftW-1:0] dabble4(input logic [ShiftW-1:0] sr_in);
    logic [ShiftW-1:0] sr;
    sr = sr_in;
    for (int s = 0; s < 4; s++) begin
      for (int d = 0; d < 5; d++) begin
        if (sr[ValueW+4*d +: 4] >= 4'd5) begin
          sr[ValueW+4*d +: 4] = sr[ValueW+4*d +: 4] + 4'd3;
        end
      end
      sr = {sr[ShiftW-2:0], 1'b0};
    end
    return sr;
  endfunction

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    return (nib > 4'd9) ? ({4'd0, nib} + CHAR_ALPHA) : ({4'd0, nib} + CHAR_ZERO);
  endfunction

  logic [CmdW-1:0]   in_cmd;
  logic [ValueW-1:0] in_value;
  logic [7:0]        in_lo;
  pipe_t             in_item;

  logic [Stages-1:0] vld_q, vld_d;
  logic [Stages:0]   rdy;
  pipe_t             stg_q [Stages];
  pipe_t             stg_d [Stages];

  logic [CharW-1:0]  fmt_chars [MaxChars];
  logic [3:0]        fmt_len;
  logic [3:0]        dig [5];
  logic [2:0]        num_dig;
  pipe_t             fmt_item;

  logic [CharW-1:0]  ser_chars_q [MaxChars];
  logic [CharW-1:0]  ser_chars_d [MaxChars];
  logic [3:0]        ser_len_q, ser_len_d;
  logic [2:0]        ser_idx_q, ser_idx_d;
  logic              ser_busy_q, ser_busy_d;
  logic              out_acc, out_last, ser_free, ser_load;

  assign in_cmd   = s_axis_tdata_i[CmdW-1:0];
  assign in_value = s_axis_tdata_i[CmdW +: ValueW];
  assign in_lo    = in_value[7:0];

  always_comb begin
    in_item       = '0;
    in_item.cmd   = in_cmd;
    in_item.value = in_value;
    in_item.neg   = (in_cmd == CMD_SDEC_BYTE) && in_lo[7];
    if (in_cmd == CMD_UDEC_WORD) begin
      in_item.sr[ValueW-1:0] = in_value;
    end else if (in_item.neg) begin
      in_item.sr[ValueW-1:0] = {8'd0, 8'(-in_lo)};
    end else begin
      in_item.sr[ValueW-1:0] = {8'd0, in_lo};
    end
  end

  always_comb begin
    rdy[Stages] = ser_free || (fmt_len == 4'd0);
    for (int k = Stages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    stg_d[0] = rdy[0] ? in_item : stg_q[0];
    vld_d[0] = rdy[0] ? s_axis_tvalid_i : vld_q[0];
    for (int k = 1; k < Stages; k++) begin
      stg_d[k] = rdy[k] ? pipe_t'({stg_q[k-1].cmd, stg_q[k-1].value, stg_q[k-1].neg,
                                   dabble4(stg_q[k-1].sr)})
                        : stg_q[k];
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  assign s_axis_tready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Stages; k++) begin
      stg_q[k] <= stg_d[k];
    end
  end

  assign fmt_item = stg_q[Stages-1];

  always_comb begin
    for (int d = 0; d < 5; d++) begin
      dig[d] = fmt_item.sr[ValueW+4*d +: 4];
    end
    if (dig[4] != 4'd0) begin
      num_dig = 3'd5;
    end else if (dig[3] != 4'd0) begin
      num_dig = 3'd4;
    end else if (dig[2] != 4'd0) begin
      num_dig = 3'd3;
    end else if (dig[1] != 4'd0) begin
      num_dig = 3'd2;
    end else begin
      num_dig = 3'd1;
    end
  end

  always_comb begin
    for (int p = 0; p < MaxChars; p++) begin
      fmt_chars[p] = '0;
    end
    fmt_len = '0;
    case (fmt_item.cmd)
      CMD_HEX_BYTE: begin
        fmt_chars[0] = hex_char(fmt_item.value[7:4]);
        fmt_chars[1] = hex_char(fmt_item.value[3:0]);
        fmt_len      = 4'd2;
      end
      CMD_HEX_WORD: begin
        fmt_chars[0] = hex_char(fmt_item.value[15:12]);
        fmt_chars[1] = hex_char(fmt_item.value[11:8]);
        fmt_chars[2] = hex_char(fmt_item.value[7:4]);
        fmt_chars[3] = hex_char(fmt_item.value[3:0]);
        fmt_len      = 4'd4;
      end
      CMD_BIN_BYTE: begin
        for (int p = 0; p < 8; p++) begin
          fmt_chars[p] = fmt_item.value[7-p] ? CHAR_ONE : CHAR_ZERO;
        end
        fmt_len = 4'd8;
      end
      CMD_UDEC_BYTE, CMD_SDEC_BYTE, CMD_UDEC_WORD: begin
        if (fmt_item.neg) begin
          fmt_chars[0] = CHAR_MINUS;
          for (int p = 0; p < 5; p++) begin
            if (3'(p) < num_dig) begin
              fmt_chars[p+1] = {4'd0, dig[num_dig - 3'(p) - 3'd1]} + CHAR_ZERO;
            end
          end
        end else begin
          for (int p = 0; p < 5; p++) begin
            if (3'(p) < num_dig) begin
              fmt_chars[p] = {4'd0, dig[num_dig - 3'(p) - 3'd1]} + CHAR_ZERO;
            end
          end
        end
        fmt_len = {1'b0, num_dig} + {3'd0, fmt_item.neg};
      end
      CMD_NEWLINE: begin
        fmt_chars[0] = CHAR_CR;
        fmt_chars[1] = CHAR_LF;
        fmt_len      = 4'd2;
      end
      default: begin
        fmt_len = '0;
      end
    endcase
  end

  assign out_acc  = ser_busy_q && m_axis_tready_i;
  assign out_last = (({1'b0, ser_idx_q} + 4'd1) == ser_len_q);
  assign ser_free = !ser_busy_q || (out_acc && out_last);
  assign ser_load = vld_q[Stages-1] && ser_free && (fmt_len != 4'd0);

  always_comb begin
    ser_chars_d = ser_chars_q;
    ser_len_d   = ser_len_q;
    ser_idx_d   = ser_idx_q;
    ser_busy_d  = ser_busy_q;
    if (ser_load) begin
      ser_chars_d = fmt_chars;
      ser_len_d   = fmt_len;
      ser_idx_d   = '0;
      ser_busy_d  = 1'b1;
    end else if (out_acc) begin
      if (out_last) begin
        ser_busy_d = 1'b0;
      end else begin
        ser_idx_d = ser_idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_busy_q <= 1'b0;
      ser_idx_q  <= '0;
      ser_len_q  <= '0;
    end else begin
      ser_busy_q <= ser_busy_d;
      ser_idx_q  <= ser_idx_d;
      ser_len_q  <= ser_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ser_chars_q <= ser_chars_d;
  end

  assign m_axis_tvalid_o = ser_busy_q;
  assign m_axis_tdata_o  = ser_chars_q[ser_idx_q];
  assign m_axis_tlast_o  = out_last;

  `N2A_ASSERT_NOW(a_idx_in_run, clk_i, rst_ni, ser_busy_q,
                  ({1'b0, ser_idx_q} < ser_len_q) && (ser_len_q <= 4'd8))
  `N2A_ASSERT_NOW(a_load_when_free, clk_i, rst_ni, ser_load,
                  !ser_busy_q || (out_acc && out_last))
  `N2A_ASSERT_NEXT(a_run_ends, clk_i, rst_ni, out_acc && out_last && !ser_load,
                   !m_axis_tvalid_o)

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Number to ASCII formatter testbench
// Items go in on the input stream, first a directed set covering every
// command, the field extremes, the most negative signed byte, the unused
// command and the ignored high bits of byte modes, then random items over
// four phases of sender idling and receiver stalling. Every item is
// predicted into a queue of expected characters, and each character on the
// output stream is checked against the oldest one.
// -----------------------------------------------------------------------------
module tb;
  import n2a_pkg::*;

  localparam logic [CmdW-1:0] CMD_UNUSED = 3'd7;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [ValueW-1:0] value;
  } fmt_req_t;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } text_char_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic [InDataW-1:0]  s_data = '0;
  logic                m_ready = 1'b0;
  logic                s_ready;
  logic                m_valid;
  logic [OutDataW-1:0] m_data;
  logic                m_last;

  fmt_req_t         req_q[$];
  text_char_t       text_exp_q[$];
  logic [CharW-1:0] text_q[$];
  int unsigned      send_idle_pct = 0;
  int unsigned      rx_stall_pct = 0;
  int unsigned      err_cnt = 0;

  number_to_ascii_formatter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [CharW-1:0] hex_digit(input logic [3:0] nib);
    return (nib > 4'd9) ? CHAR_ALPHA + {4'd0, nib} : CHAR_ZERO + {4'd0, nib};
  endfunction

  function automatic void add_dec_byte(input int unsigned mag);
    int unsigned hundreds;
    int unsigned tens;
    hundreds = mag / 100;
    tens = (mag % 100) / 10;
    if (hundreds != 0) text_q.push_back(CHAR_ZERO + 8'(hundreds));
    if (hundreds != 0 || tens != 0) text_q.push_back(CHAR_ZERO + 8'(tens));
    text_q.push_back(CHAR_ZERO + 8'(mag % 10));
  endfunction

  function automatic void predict_text(input logic [CmdW-1:0] cmd,
                                       input logic [ValueW-1:0] value);
    logic [7:0]  lo;
    int unsigned rem;
    int unsigned div;
    int unsigned dig;
    bit          started;
    lo = value[7:0];
    text_q.delete();
    case (cmd)
      CMD_HEX_BYTE: begin
        text_q.push_back(hex_digit(lo[7:4]));
        text_q.push_back(hex_digit(lo[3:0]));
      end
      CMD_HEX_WORD: begin
        for (int n = 3; n >= 0; n--) text_q.push_back(hex_digit(value[4*n +: 4]));
      end
      CMD_BIN_BYTE: begin
        for (int b = 7; b >= 0; b--) text_q.push_back(lo[b] ? CHAR_ONE : CHAR_ZERO);
      end
      CMD_UDEC_BYTE: add_dec_byte(32'(lo));
      CMD_SDEC_BYTE: begin
        if (lo[7]) begin
          text_q.push_back(CHAR_MINUS);
          add_dec_byte(32'd256 - 32'(lo));
        end else begin
          add_dec_byte(32'(lo));
        end
      end
      CMD_UDEC_WORD: begin
        rem = 32'(value);
        started = 1'b0;
        div = 10000;
        while (div != 0) begin
          dig = rem / div;
          if (dig != 0 || started || div == 1) begin
            text_q.push_back(CHAR_ZERO + 8'(dig));
            started = 1'b1;
            rem -= dig * div;
          end
          div /= 10;
        end
      end
      CMD_NEWLINE: begin
        text_q.push_back(CHAR_CR);
        text_q.push_back(CHAR_LF);
      end
      default: ;
    endcase
    foreach (text_q[i]) text_exp_q.push_back('{ch: text_q[i], last: (i == text_q.size() - 1)});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    fmt_req_t nxt;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data <= '0;
    end else if (!s_valid || s_ready) begin
      if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = req_q.pop_front();
        s_valid <= 1'b1;
        s_data <= {{(InDataW-CmdW-ValueW){1'b0}}, nxt.value, nxt.cmd};
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watch_streams
    text_char_t want;
    if (rst_ni) begin
      if (s_valid && s_ready) predict_text(s_data[CmdW-1:0], s_data[CmdW +: ValueW]);
      if (m_valid && m_ready) begin
        if (text_exp_q.size() == 0) begin
          $display("%0t: unexpected character %h last %b", $time, m_data, m_last);
          err_cnt++;
        end else begin
          want = text_exp_q.pop_front();
          if (m_data !== want.ch) begin
            $display("%0t: character expected %h actual %h", $time, want.ch, m_data);
            err_cnt++;
          end
          if (m_last !== want.last) begin
            $display("%0t: last flag expected %b actual %b", $time, want.last, m_last);
            err_cnt++;
          end
        end
      end
    end
  end

  task automatic add_req(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] value);
    req_q.push_back('{cmd: cmd, value: value});
  endtask

  task automatic add_random_reqs(input int n);
    int unsigned pick;
    logic [CmdW-1:0] cmd;
    logic [ValueW-1:0] value;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 15);
      cmd = (pick < 14) ? CmdW'(pick % 7) : CMD_UNUSED;
      value = ($urandom_range(0, 3) == 0) ? ValueW'($urandom_range(0, 120))
                                          : ValueW'($urandom);
      add_req(cmd, value);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_q.size() != 0 || s_valid || text_exp_q.size() != 0);
  endtask

  initial begin
    int unsigned send_idle_tbl[4];
    int unsigned rx_stall_tbl[4];
    send_idle_tbl = '{0, 81, 0, 33};
    rx_stall_tbl = '{0, 0, 81, 33};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_req(CMD_HEX_BYTE, 16'h0000);
    add_req(CMD_HEX_BYTE, 16'hABFF);
    add_req(CMD_HEX_WORD, 16'h0000);
    add_req(CMD_HEX_WORD, 16'hFFFF);
    add_req(CMD_HEX_WORD, 16'h1A2F);
    add_req(CMD_BIN_BYTE, 16'h0055);
    add_req(CMD_BIN_BYTE, 16'hFFAA);
    add_req(CMD_UDEC_BYTE, 16'h0000);
    add_req(CMD_UDEC_BYTE, 16'h0009);
    add_req(CMD_UDEC_BYTE, 16'h0063);
    add_req(CMD_UDEC_BYTE, 16'h0064);
    add_req(CMD_UDEC_BYTE, 16'hFFFF);
    add_req(CMD_SDEC_BYTE, 16'h0080);
    add_req(CMD_SDEC_BYTE, 16'h007F);
    add_req(CMD_SDEC_BYTE, 16'hFFFF);
    add_req(CMD_SDEC_BYTE, 16'h0000);
    add_req(CMD_SDEC_BYTE, 16'h559C);
    add_req(CMD_UDEC_WORD, 16'h0000);
    add_req(CMD_UDEC_WORD, 16'd9999);
    add_req(CMD_UDEC_WORD, 16'd10000);
    add_req(CMD_UDEC_WORD, 16'hFFFF);
    add_req(CMD_NEWLINE, 16'h0000);
    add_req(CMD_UNUSED, 16'hFFFF);
    add_req(CMD_NEWLINE, 16'hFFFF);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_idle_tbl[ph];
      rx_stall_pct = rx_stall_tbl[ph];
      add_random_reqs(44);
      wait_drained();
    end
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
